// ===== design/s2l_pkg.sv =====
// Shared constants, coefficient tables and table-building functions for the sRGB to L*a*b* core.
package s2l_pkg;

  // Default fraction widths of the internal and the output fixed-point formats
  localparam int unsigned IntFracBits = 16;
  localparam int unsigned OutFracBits = 8;

  // Depth of the request queue between the front and the back
  localparam int unsigned QueueDepth = 2;

  // Stream widths
  localparam int unsigned PixW = 24;
  localparam int unsigned LabW = 48;

  // Width of the matrix coefficients and divisors
  localparam int unsigned CoefW = 24;

  // sRGB to XYZ matrix, rows X, Y, Z, in units of 1e-7
  localparam logic [CoefW-1:0] MatCoef [3][3] = '{
    '{24'd4124564, 24'd3575761, 24'd1804375},
    '{24'd2126729, 24'd7151522, 24'd721750},
    '{24'd193339,  24'd1191920, 24'd9503041}
  };

  // Rounding offsets and white-point divisors per row
  localparam logic [CoefW-1:0] MatRnd [3] = '{24'd4752350, 24'd5000000, 24'd5444150};
  localparam logic [CoefW-1:0] MatDiv [3] = '{24'd9504700, 24'd10000000, 24'd10888300};

  // Linear segment of the Lab curve
  localparam int unsigned LinSegW = 12;
  localparam logic [LinSegW-1:0] LinSegDiv = 12'd3132;

  // Fifth power in Q0.31
  function automatic longint unsigned fifth_pow(input longint unsigned r);
    longint unsigned r2;
    longint unsigned r4;
    r2 = (r * r) >> 31;
    r4 = (r2 * r2) >> 31;
    fifth_pow = (r4 * r) >> 31;
  endfunction

  // Linear light of one sRGB byte in Q0.f
  function automatic longint unsigned lin_value(input longint unsigned v, input int unsigned f);
    longint unsigned num;
    longint unsigned u;
    longint unsigned u2;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    longint unsigned y;
    num = (v * 64'd100) << f;
    if (v <= 64'd10) begin
      lin_value = num / 64'd329460 + ((num % 64'd329460 >= 64'd164730) ? 64'd1 : 64'd0);
    end else begin
      u = (((64'd1000 * v + 64'd14025) << 31) + 64'd134512) / 64'd269025;
      u2 = (u * u) >> 31;
      lo = 64'd0;
      hi = 64'd1 << 31;
      for (int k = 0; k < 34; k++) begin
        if (lo < hi) begin
          mid = (lo + hi + 64'd1) >> 1;
          if (fifth_pow(mid) <= u2) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      y = (u2 * lo) >> 31;
      lin_value = (y + (64'd1 << (30 - f))) >> (31 - f);
    end
  endfunction

endpackage

// ===== design/s2l_front.sv =====
// Front end: takes pixel requests, linearises each channel by table and hands them to the queue.
module s2l_front import s2l_pkg::*; #(
  parameter int unsigned IntFrac = IntFracBits,
  localparam int unsigned LinW = IntFrac + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PixW-1:0]     in_data_i,
  input  logic                full_i,
  output logic                push_o,
  output logic [3*LinW-1:0]   lin_o
);

  logic [LinW-1:0]   lin_tab [256];
  logic              valid_q;
  logic [3*LinW-1:0] lin_q;
  logic              accept;

  // Build the transfer-curve table
  for (genvar v = 0; v < 256; v++) begin : g_tab
    assign lin_tab[v] = LinW'(lin_value(longint'(v), IntFrac));
  end

  // Hand over whenever the queue has room
  assign push_o     = valid_q && !full_i;
  assign in_ready_o = !valid_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign lin_o      = lin_q;

  // Hold the request flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Capture the linearised channels
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lin_q <= {lin_tab[in_data_i[23:16]], lin_tab[in_data_i[15:8]], lin_tab[in_data_i[7:0]]};
    end
  end

endmodule

// ===== design/s2l_queue.sv =====
// Short request queue between the front and the back.
module s2l_queue import s2l_pkg::*; #(
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1,
  localparam int unsigned CntW = $clog2(QueueDepth + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem [QueueDepth];
  logic [AddrW-1:0] wr_ptr_q;
  logic [AddrW-1:0] rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o  = count_q == CntW'(QueueDepth);
  assign valid_o = count_q != '0;
  assign data_o  = mem[rd_ptr_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/s2l_div3.sv =====
// Three-lane divider by constants: reciprocal estimate, remainder check and correction.
module s2l_div3 import s2l_pkg::*; #(
  parameter int unsigned NumW = 32,
  parameter int unsigned QuoW = 16,
  parameter int unsigned DivW = 16,
  parameter int unsigned PassW = 1,
  parameter logic [DivW-1:0] Div0 = '1,
  parameter logic [DivW-1:0] Div1 = '1,
  parameter logic [DivW-1:0] Div2 = '1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [2:0][NumW-1:0]  num_i,
  input  logic [PassW-1:0]      pass_i,
  output logic [2:0][QuoW-1:0]  quo_o,
  output logic [PassW-1:0]      pass_o
);

  // Every divisor has its top bit set, so the estimate falls short by at most two
  localparam int unsigned Sh = DivW - 1;
  localparam int unsigned HiW = NumW - Sh;
  localparam int unsigned RecW = NumW + 3 - DivW;
  localparam int unsigned EstW = HiW + RecW;
  localparam int unsigned EstSh = NumW - DivW + 2;
  localparam int unsigned QeW = NumW - DivW + 1;
  localparam int unsigned MulW = QeW + DivW;
  localparam int unsigned RemW = DivW + 2;
  localparam int unsigned Stages = 3;

  localparam logic [DivW-1:0] Divs [3] = '{Div0, Div1, Div2};
  localparam logic [RecW-1:0] Recs [3] = '{
    RecW'((64'd1 << (NumW + 1)) / 64'(Div0)),
    RecW'((64'd1 << (NumW + 1)) / 64'(Div1)),
    RecW'((64'd1 << (NumW + 1)) / 64'(Div2))
  };

  logic [PassW-1:0] pass_q [Stages];

  // Carry the side band along the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) begin
        pass_q[s] <= '0;
      end
    end else if (en_i) begin
      pass_q[0] <= pass_i;
      for (int s = 1; s < Stages; s++) begin
        pass_q[s] <= pass_q[s-1];
      end
    end
  end

  assign pass_o = pass_q[Stages-1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [EstW-1:0] est_full;
    logic [QeW-1:0]  est_q;
    logic [NumW-1:0] num_q;
    logic [MulW-1:0] back_mul;
    logic [NumW-1:0] rem_full;
    logic [QeW-1:0]  est2_q;
    logic [RemW-1:0] rem_q;
    logic [QeW-1:0]  fix;
    logic [QuoW-1:0] quo_q;

    // Estimate the quotient from the upper numerator bits
    assign est_full = EstW'(num_i[l][NumW-1:Sh]) * EstW'(Recs[l]);

    // Multiply the estimate back to find what is left over
    assign back_mul = MulW'(est_q) * MulW'(Divs[l]);
    assign rem_full = num_q - NumW'(back_mul);

    // Add the one or two divisors that the estimate fell short by
    assign fix = (rem_q >= (RemW'(Divs[l]) << 1)) ? QeW'(2)
               : ((rem_q >= RemW'(Divs[l])) ? QeW'(1) : '0);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        est_q  <= QeW'(est_full >> EstSh);
        num_q  <= num_i[l];
        est2_q <= est_q;
        rem_q  <= RemW'(rem_full);
        quo_q  <= QuoW'(est2_q + fix);
      end
    end

    assign quo_o[l] = quo_q;
  end

endmodule

// ===== design/s2l_cbrt3.sv =====
// Three-lane floor cube root in Q.F, one result bit per two stages.
module s2l_cbrt3 import s2l_pkg::*; #(
  parameter int unsigned IntFrac = IntFracBits,
  parameter int unsigned PassW = 1,
  localparam int unsigned RootW = IntFrac + 1,
  localparam int unsigned ArgW = IntFrac + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic [2:0][ArgW-1:0]   t_i,
  input  logic [PassW-1:0]       pass_i,
  output logic [2:0][RootW-1:0]  root_o,
  output logic [2:0][ArgW-1:0]   t_o,
  output logic [PassW-1:0]       pass_o
);

  localparam int unsigned SqFullW = 2 * RootW;
  localparam int unsigned SqW = SqFullW - IntFrac;
  localparam int unsigned CbFullW = SqW + RootW;
  localparam int unsigned CbW = CbFullW - IntFrac;
  localparam int unsigned Stages = 2 * RootW;

  logic [PassW-1:0] pass_q [Stages];

  // Carry the side band along the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < Stages; s++) begin
        pass_q[s] <= '0;
      end
    end else if (en_i) begin
      pass_q[0] <= pass_i;
      for (int s = 1; s < Stages; s++) begin
        pass_q[s] <= pass_q[s-1];
      end
    end
  end

  assign pass_o = pass_q[Stages-1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [RootW-1:0] r_in  [RootW];
    logic [ArgW-1:0]  t_in  [RootW];
    logic [RootW-1:0] tr_d  [RootW];
    logic [SqW-1:0]   sq_d  [RootW];
    logic [RootW-1:0] rb_d  [RootW];
    logic [RootW-1:0] tr_q  [RootW];
    logic [SqW-1:0]   sq_q  [RootW];
    logic [RootW-1:0] ra_q  [RootW];
    logic [ArgW-1:0]  ta_q  [RootW];
    logic [RootW-1:0] rb_q  [RootW];
    logic [ArgW-1:0]  tb_q  [RootW];

    assign r_in[0] = '0;
    assign t_in[0] = t_i[l];
    for (genvar k = 1; k < RootW; k++) begin : g_link
      assign r_in[k] = rb_q[k-1];
      assign t_in[k] = tb_q[k-1];
    end

    // Square the trial value, then cube it and keep the bit if it does not exceed t
    always_comb begin
      logic [RootW-1:0]   trial;
      logic [SqFullW-1:0] sq_full;
      logic [CbFullW-1:0] cb_full;
      for (int k = 0; k < RootW; k++) begin
        trial   = r_in[k] | (RootW'(1) << (RootW - 1 - k));
        sq_full = SqFullW'(trial) * SqFullW'(trial);
        tr_d[k] = trial;
        sq_d[k] = sq_full[SqFullW-1:IntFrac];
        cb_full = CbFullW'(sq_q[k]) * CbFullW'(tr_q[k]);
        rb_d[k] = (cb_full[CbFullW-1:IntFrac] <= CbW'(ta_q[k])) ? tr_q[k] : ra_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int k = 0; k < RootW; k++) begin
          tr_q[k] <= tr_d[k];
          sq_q[k] <= sq_d[k];
          ra_q[k] <= r_in[k];
          ta_q[k] <= t_in[k];
          rb_q[k] <= rb_d[k];
          tb_q[k] <= ta_q[k];
        end
      end
    end

    assign root_o[l] = rb_q[RootW-1];
    assign t_o[l]    = tb_q[RootW-1];
  end

endmodule

// ===== design/s2l_back.sv =====
// Back end: matrix, white-point division, Lab curve and output formatting in one stalling pipeline.
module s2l_back import s2l_pkg::*; #(
  parameter int unsigned IntFrac = IntFracBits,
  parameter int unsigned OutFrac = OutFracBits,
  localparam int unsigned LinW = IntFrac + 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3*LinW-1:0]   lin_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LabW-1:0]     out_data_o
);

  localparam int unsigned ProdW = LinW + CoefW;
  localparam int unsigned NumW = ProdW + 2;
  localparam int unsigned ArgW = IntFrac + 2;
  localparam int unsigned RootW = IntFrac + 1;
  localparam int unsigned LinNumW = ArgW + 16;
  localparam int unsigned LinPassW = 1 + 3 * RootW + 3;
  localparam int unsigned ResW = IntFrac + 12;
  localparam int unsigned Shift = IntFrac - OutFrac;
  localparam logic signed [ResW-1:0] LMax = ResW'(100 << OutFrac);
  localparam logic signed [ResW-1:0] AxMax = ResW'(32767);
  localparam logic signed [ResW-1:0] AxMin = -(ResW'(32768));

  logic en;

  logic                  v1_q;
  logic [ProdW-1:0]      prod_q [3][3];
  logic                  v2_q;
  logic [2:0][NumW-1:0]  num_q;
  logic [2:0][ArgW-1:0]  t_mat;
  logic                  v3;
  logic [2:0][RootW-1:0] root;
  logic [2:0][ArgW-1:0]  t_cb;
  logic                  v4;
  logic                  v5_q;
  logic [2:0][LinNumW-1:0] lnum_q;
  logic [2:0][RootW-1:0] root5_q;
  logic [2:0]            cube5_q;
  logic [2:0][RootW-1:0] lin_quo;
  logic [LinPassW-1:0]   lpass;
  logic [2:0][RootW-1:0] root6;
  logic [2:0]            cube6;
  logic                  v6;
  logic                  v7_q;
  logic signed [ResW-1:0] lp_q;
  logic signed [ResW-1:0] ap_q;
  logic signed [ResW-1:0] bp_q;
  logic                  out_valid_q;
  logic [LabW-1:0]       out_data_q;

  // Round half away from zero and drop the extra fraction bits
  function automatic logic signed [ResW-1:0] rnd(input logic signed [ResW-1:0] v);
    logic [ResW-1:0] mag;
    logic [ResW-1:0] q;
    mag = v[ResW-1] ? ResW'(-v) : ResW'(v);
    q = (mag + (ResW'(1) << (Shift - 1))) >> Shift;
    rnd = v[ResW-1] ? -signed'(q) : signed'(q);
  endfunction

  // Advance the whole pipeline unless the output register is held
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Matrix products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= ProdW'(MatCoef[r][c]) * ProdW'(lin_i[c*LinW +: LinW]);
        end
      end
    end
  end

  // Row sums with rounding offset
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        num_q[r] <= NumW'(prod_q[r][0]) + NumW'(prod_q[r][1]) + NumW'(prod_q[r][2])
                  + NumW'(MatRnd[r]);
      end
    end
  end

  // Divide by the white-point row divisors
  s2l_div3 #(
    .NumW  (NumW),
    .QuoW  (ArgW),
    .DivW  (CoefW),
    .PassW (1),
    .Div0  (MatDiv[0]),
    .Div1  (MatDiv[1]),
    .Div2  (MatDiv[2])
  ) u_mat_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (num_q),
    .pass_i (v2_q),
    .quo_o  (t_mat),
    .pass_o (v3)
  );

  // Cube-root branch
  s2l_cbrt3 #(
    .IntFrac (IntFrac),
    .PassW   (1)
  ) u_cbrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .t_i    (t_mat),
    .pass_i (v3),
    .root_o (root),
    .t_o    (t_cb),
    .pass_o (v4)
  );

  // Linear-segment numerator and branch choice
  always_ff @(posedge clk_i) begin
    logic [LinNumW-1:0] tk;
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        tk = LinNumW'(t_cb[l]) * LinNumW'(24389);
        lnum_q[l]  <= tk + (LinNumW'(432) << IntFrac) + LinNumW'(1566);
        cube5_q[l] <= tk > (LinNumW'(216) << IntFrac);
        root5_q[l] <= root[l];
      end
    end
  end

  s2l_div3 #(
    .NumW  (LinNumW),
    .QuoW  (RootW),
    .DivW  (LinSegW),
    .PassW (LinPassW),
    .Div0  (LinSegDiv),
    .Div1  (LinSegDiv),
    .Div2  (LinSegDiv)
  ) u_lin_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .num_i  (lnum_q),
    .pass_i ({cube5_q, root5_q, v5_q}),
    .quo_o  (lin_quo),
    .pass_o (lpass)
  );

  assign {cube6, root6, v6} = lpass;

  // Pick the curve branch and scale into L*, a*, b*
  always_ff @(posedge clk_i) begin
    logic signed [ResW-1:0] fx;
    logic signed [ResW-1:0] fy;
    logic signed [ResW-1:0] fz;
    if (en) begin
      fx = signed'(ResW'(cube6[0] ? root6[0] : lin_quo[0]));
      fy = signed'(ResW'(cube6[1] ? root6[1] : lin_quo[1]));
      fz = signed'(ResW'(cube6[2] ? root6[2] : lin_quo[2]));
      lp_q <= ResW'(116) * fy - (ResW'(16) << IntFrac);
      ap_q <= ResW'(500) * (fx - fy);
      bp_q <= ResW'(200) * (fy - fz);
    end
  end

  // Round, saturate and register the result
  always_ff @(posedge clk_i) begin
    logic signed [ResW-1:0] lr;
    logic signed [ResW-1:0] ar;
    logic signed [ResW-1:0] br;
    if (en) begin
      lr = rnd(lp_q);
      ar = rnd(ap_q);
      br = rnd(bp_q);
      lr = (lr < 0) ? '0 : ((lr > LMax) ? LMax : lr);
      ar = (ar > AxMax) ? AxMax : ((ar < AxMin) ? AxMin : ar);
      br = (br > AxMax) ? AxMax : ((br < AxMin) ? AxMin : br);
      out_data_q <= {1'b0, br[15:0], ar[15:0], lr[14:0]};
    end
  end

  // Valid flags of the local stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v5_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v5_q        <= v4;
      v7_q        <= v6;
      out_valid_q <= v7_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/srgb8_to_cielab_core.sv =====
// Top level of the 8-bit sRGB to CIE L*a*b* (D65) stream converter.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata: red[7:0] green[15:8] blue[23:16]
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata: L[14:0] a[30:15] b[46:31], 0 pad
//
//  One pixel per clock sustained while m_axis takes results; the pipeline depth is
//  set mostly by the two-stage-per-bit cube root, then by the two constant dividers.
//  The back pipeline moves as a whole and stops only while m_axis holds a result;
//  a two-entry queue lets the front keep taking pixels meanwhile.
//  Reset clears only valid flags, side bands, queue pointers and count; no clearing pass.
module srgb8_to_cielab_core import s2l_pkg::*; #(
  parameter int unsigned INTERNAL_FRACTION_BITS = IntFracBits,
  parameter int unsigned OUTPUT_FRACTION_BITS = OutFracBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [PixW-1:0] s_axis_tdata,   // red, green, blue
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [LabW-1:0] m_axis_tdata    // lightness, green_red_axis, blue_yellow_axis, pad
);

  localparam int unsigned LinW = INTERNAL_FRACTION_BITS + 1;

  logic              push;
  logic              q_full;
  logic [3*LinW-1:0] front_lin;
  logic              q_valid;
  logic [3*LinW-1:0] q_lin;
  logic              back_ready;
  logic              pop;

  // Accept and linearise
  s2l_front #(
    .IntFrac (INTERNAL_FRACTION_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .full_i     (q_full),
    .push_o     (push),
    .lin_o      (front_lin)
  );

  // Decouple front and back
  s2l_queue #(
    .Width (3 * LinW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_lin),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (q_lin)
  );

  assign pop = q_valid && back_ready;

  // Convert to Lab
  s2l_back #(
    .IntFrac (INTERNAL_FRACTION_BITS),
    .OutFrac (OUTPUT_FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (back_ready),
    .lin_i       (q_lin),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !q_full)
    else $error("queue overrun");

  // Lightness stays within 0..100
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[14:0] <= 15'(100 << OUTPUT_FRACTION_BITS))
    else $error("lightness out of range");

  // Pad bit stays clear
  assert property (@(posedge clk_i) disable iff (!rst_ni) m_axis_tvalid |-> !m_axis_tdata[47])
    else $error("pad bit set");

endmodule

// ===== tb/sv/tb.sv =====
// Stream testbench for the sRGB to CIE L*a*b* converter core.
`timescale 1ns / 100ps

module tb;
  import s2l_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned OutBits = 8;
  localparam int unsigned RandPixels = 1030;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 200;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct {
    logic [14:0] lightness;
    logic [15:0] green_red;
    logic [15:0] blue_yellow;
  } lab_t;

  typedef struct {
    pixel_t pix;
    bit     known;
    lab_t   lab;
  } stim_row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            s_axis_tvalid;
  logic            s_axis_tready;
  logic [PixW-1:0] s_axis_tdata;
  logic            m_axis_tvalid;
  logic            m_axis_tready;
  logic [LabW-1:0] m_axis_tdata;

  srgb8_to_cielab_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),    // red, green, blue
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)     // lightness, green_red_axis, blue_yellow_axis, pad
  );

  longint unsigned lin_lut [256];
  lab_t            lab_queue [$];
  stim_row_t       stim_rows [$];
  int unsigned     error_count;
  int unsigned     lab_checked;
  int unsigned     idle_cycles;
  bit              stim_done;
  bit              calm_phase;

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Linear light of one byte in Q0.16
  function automatic longint unsigned byte_linear(input longint unsigned v);
    longint unsigned num, u, u2, lo, hi, mid, r2, r4, y;
    num = (v * 100) << FracBits;
    if (v <= 10) return num / 329460 + ((num % 329460 >= 164730) ? 1 : 0);
    u = (((1000 * v + 14025) << 31) + 134512) / 269025;
    u2 = (u * u) >> 31;
    lo = 0;
    hi = 64'd1 << 31;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      r2 = (mid * mid) >> 31;
      r4 = (r2 * r2) >> 31;
      if (((r4 * mid) >> 31) <= u2) lo = mid;
      else hi = mid - 1;
    end
    y = (u2 * lo) >> 31;
    return (y + (64'd1 << (30 - FracBits))) >> (31 - FracBits);
  endfunction

  // Lab curve: exact floor cube root above the knee, linear segment below
  function automatic longint lab_curve(input longint unsigned t);
    longint unsigned lo, hi, mid;
    if (t * 24389 > (64'd216 << FracBits)) begin
      lo = 0;
      hi = 64'd2 << FracBits;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (((((mid * mid) >> FracBits) * mid) >> FracBits) <= t) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    end
    return (t * 24389 + (64'd432 << FracBits) + 1566) / 3132;
  endfunction

  // Shift right, rounding half away from zero
  function automatic longint round_shift(input longint v);
    longint half;
    half = 64'sd1 <<< (FracBits - OutBits - 1);
    if (v < 0) return -((-v + half) >>> (FracBits - OutBits));
    return (v + half) >>> (FracBits - OutBits);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Convert one pixel to saturated L*a*b*
  function automatic lab_t convert_pixel(input pixel_t p);
    longint unsigned r, g, b, tx, ty, tz;
    longint fx, fy, fz;
    lab_t res;
    r = lin_lut[p.red];
    g = lin_lut[p.green];
    b = lin_lut[p.blue];
    tx = (4124564 * r + 3575761 * g + 1804375 * b + 4752350) / 9504700;
    ty = (2126729 * r + 7151522 * g + 721750 * b + 5000000) / 10000000;
    tz = (193339 * r + 1191920 * g + 9503041 * b + 5444150) / 10888300;
    fx = lab_curve(tx);
    fy = lab_curve(ty);
    fz = lab_curve(tz);
    res.lightness = 15'(clamp(round_shift(116 * fy - (64'sd16 <<< FracBits)), 0,
                              64'sd100 <<< OutBits));
    res.green_red = 16'(clamp(round_shift(500 * (fx - fy)), -32768, 32767));
    res.blue_yellow = 16'(clamp(round_shift(200 * (fy - fz)), -32768, 32767));
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_v);
    $display("MISMATCH %s: got %0d, expected %0d (result %0d)", what, got, exp_v, lab_checked);
    error_count++;
  endtask

  task automatic add_row(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                         input bit known, input int l, input int a, input int bb);
    stim_row_t row;
    row.pix = '{blue: b, green: g, red: r};
    row.known = known;
    row.lab = '{lightness: 15'(l), green_red: 16'(a), blue_yellow: 16'(bb)};
    stim_rows.push_back(row);
  endtask

  // Drive one request, holding valid until accepted
  task automatic send_pixel(input pixel_t p);
    int gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= p;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Record expectation for each accepted request
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      lab_queue.push_back(convert_pixel(pixel_t'(s_axis_tdata)));
    end
  end

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    lab_t exp_lab;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (lab_queue.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[14:0], -1);
      end else begin
        exp_lab = lab_queue.pop_front();
        if (m_axis_tdata[14:0] !== exp_lab.lightness)
          report_mismatch("lightness", m_axis_tdata[14:0], exp_lab.lightness);
        if (m_axis_tdata[30:15] !== exp_lab.green_red)
          report_mismatch("green_red_axis", $signed(m_axis_tdata[30:15]),
                          $signed(exp_lab.green_red));
        if (m_axis_tdata[46:31] !== exp_lab.blue_yellow)
          report_mismatch("blue_yellow_axis", $signed(m_axis_tdata[46:31]),
                          $signed(exp_lab.blue_yellow));
      end
      lab_checked++;
    end
  end

  // Receiver stalls in random bursts, none once calm
  initial begin
    int burst;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm_phase && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        burst = $urandom_range(1, 12);
      end else begin
        m_axis_tready <= 1'b1;
        burst = $urandom_range(1, 20);
      end
      repeat (burst) @(posedge clk_i);
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni && (!stim_done || lab_queue.size() != 0)) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("Timeout: no handshake for %0d cycles", StallLimit);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    pixel_t p;
    lab_t e;
    int n, wait_cnt;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    error_count = 0;
    lab_checked = 0;
    idle_cycles = 0;
    stim_done = 1'b0;
    calm_phase = 1'b0;
    for (int v = 0; v < 256; v++) lin_lut[v] = byte_linear(v);

    // Directed table: black and white read off directly, the rest predicted
    add_row(8'h00, 8'h00, 8'h00, 1, 0, 0, 0);
    add_row(8'hFF, 8'hFF, 8'hFF, 1, 25600, 0, 0);
    add_row(8'hFF, 8'h00, 8'h00, 0, 0, 0, 0);
    add_row(8'h00, 8'hFF, 8'h00, 0, 0, 0, 0);
    add_row(8'h00, 8'h00, 8'hFF, 0, 0, 0, 0);
    add_row(8'hFF, 8'hFF, 8'h00, 0, 0, 0, 0);
    add_row(8'hFF, 8'h00, 8'hFF, 0, 0, 0, 0);
    add_row(8'h00, 8'hFF, 8'hFF, 0, 0, 0, 0);
    add_row(8'd10, 8'd10, 8'd10, 0, 0, 0, 0);
    add_row(8'd11, 8'd11, 8'd11, 0, 0, 0, 0);
    add_row(8'd1, 8'd0, 8'd0, 0, 0, 0, 0);
    add_row(8'd0, 8'd1, 8'd0, 0, 0, 0, 0);
    add_row(8'd0, 8'd0, 8'd1, 0, 0, 0, 0);
    add_row(8'd8, 8'd9, 8'd8, 0, 0, 0, 0);
    add_row(8'd20, 8'd20, 8'd20, 0, 0, 0, 0);
    add_row(8'h80, 8'h80, 8'h80, 0, 0, 0, 0);
    add_row(8'h55, 8'hAA, 8'h55, 0, 0, 0, 0);
    add_row(8'hAA, 8'h55, 8'hAA, 0, 0, 0, 0);
    add_row(8'hFE, 8'h01, 8'hFE, 0, 0, 0, 0);
    add_row(8'h01, 8'hFE, 8'h01, 0, 0, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (stim_rows[i]) begin
      if (stim_rows[i].known) begin
        e = convert_pixel(stim_rows[i].pix);
        if (e.lightness !== stim_rows[i].lab.lightness ||
            e.green_red !== stim_rows[i].lab.green_red ||
            e.blue_yellow !== stim_rows[i].lab.blue_yellow)
          report_mismatch("table row vs predictor", i, -1);
      end
      send_pixel(stim_rows[i].pix);
    end

    // Random pixels, with grey and extreme-channel mixes
    for (int k = 0; k < RandPixels; k++) begin
      calm_phase = (k >= RandPixels - 150);
      n = $urandom_range(0, 9);
      p = pixel_t'($urandom());
      if (n == 0) begin
        p.green = p.red;
        p.blue = p.red;
      end else if (n == 1) begin
        p.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        p.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else if (n == 2) begin
        p = pixel_t'($urandom() & 24'h0F0F0F);
      end
      send_pixel(p);
    end
    s_axis_tvalid <= 1'b0;
    stim_done = 1'b1;

    // Drain outstanding results, then let the pipeline settle
    wait_cnt = 0;
    while (lab_queue.size() != 0 && wait_cnt < StallLimit) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d L*a*b* results from directed extremes and random pixels,",
             lab_checked);
    $display("with random sender and receiver stalls and a final stall-free stretch.");
    if (error_count == 0 && lab_queue.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results outstanding", error_count, lab_queue.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== srgb8_to_cielab_core.f =====
design/s2l_pkg.sv
design/s2l_front.sv
design/s2l_queue.sv
design/s2l_div3.sv
design/s2l_cbrt3.sv
design/s2l_back.sv
design/srgb8_to_cielab_core.sv
tb/sv/tb.sv
